### hdl/stk500v2_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver modules.
`ifndef STK500V2_FRAME_RECEIVER_ASSERT_SVH
`define STK500V2_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STK_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STK_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/stk_pkg.sv
// Types and constants of the STK500v2 frame receiver.
package stk_pkg;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SEQ    = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_TOKEN  = 3'd4,
    PH_DATA   = 3'd5,
    PH_CHECK  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_HEADER  = 3'd0,
    K_PAYLOAD = 3'd1,
    K_GOOD    = 3'd2,
    K_BADSUM  = 3'd3,
    K_HUNT    = 3'd4,
    K_SEQREJ  = 3'd5,
    K_TOKREJ  = 3'd6,
    K_LENREJ  = 3'd7
  } kind_t;

  localparam int unsigned REG_START_MARKER = 0;
  localparam int unsigned REG_TOKEN_BYTE   = 1;

  localparam logic [7:0] START_MARKER_RST = 8'h1B;
  localparam logic [7:0] TOKEN_BYTE_RST   = 8'h0E;
  localparam logic [7:0] SEQ_RST          = 8'h01;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] token_byte;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [8:0] payload_index;
    logic [9:0] frame_length;
    logic [7:0] sequence_res;
  } result_t;

endpackage

### hdl/stk500v2_frame_receiver.sv
// Top level of the STK500v2 frame receiver: config registers, parser and result queue.
//
//   channel   handshake            payload
//   input     push / full          in_rx_byte
//   result    pop / empty          out_kind, out_data_byte, out_payload_index,
//                                  out_frame_length, out_sequence_res
//   config    cfg_we               cfg_addr, cfg_wdata
//
// One received word is taken per cycle unless the queue is full; its result enters a 4-entry
// queue at the same edge and, if the queue was empty, shows on the result ports the next cycle.
// The parser stalls only when the result queue is full (full tracks the queue count).
// Synchronous active-low reset: parser in hunting, expected sequence 1, queue empty,
// start marker 0x1B, token 0x0E.
module stk500v2_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [8:0] out_payload_index,
  output logic [9:0] out_frame_length,
  output logic [7:0] out_sequence_res,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata
);

  stk_pkg::cfg_t    cfg_r, cfg_nxt;
  stk_pkg::result_t front_res;
  stk_pkg::result_t back_res;
  logic             in_acc;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        1'(stk_pkg::REG_START_MARKER): cfg_nxt.start_marker = cfg_wdata;
        1'(stk_pkg::REG_TOKEN_BYTE):   cfg_nxt.token_byte   = cfg_wdata;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= stk_pkg::START_MARKER_RST;
      cfg_r.token_byte   <= stk_pkg::TOKEN_BYTE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_acc = push && !full;

  stk_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .acc     (in_acc),
    .rx_byte (in_rx_byte),
    .res     (front_res)
  );

  stk_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_data (front_res),
    .full    (full),
    .rd_en   (pop),
    .empty   (empty),
    .rd_data (back_res)
  );

  assign out_kind          = back_res.kind;
  assign out_data_byte     = back_res.data_byte;
  assign out_payload_index = back_res.payload_index;
  assign out_frame_length  = back_res.frame_length;
  assign out_sequence_res  = back_res.sequence_res;

endmodule

### hdl/stk_front.sv
// Front part: per-byte frame parser that classifies each received word.
module stk_front #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stk_pkg::cfg_t       cfg,
  input  logic                acc,
  input  logic [7:0]          rx_byte,
  output stk_pkg::result_t    res
);

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  stk_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      exp_seq_r, exp_seq_nxt;
  logic [7:0]      xor_r, xor_nxt;
  logic [15:0]     length_r, length_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  logic [15:0]     len_new;
  logic [CW-1:0]   count_inc;
  logic [15:0]     count_ext;
  logic [15:0]     count_inc_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= stk_pkg::PH_HUNT;
      exp_seq_r <= stk_pkg::SEQ_RST;
      xor_r     <= 8'h00;
      length_r  <= 16'h0000;
      count_r   <= '0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      exp_seq_r <= exp_seq_nxt;
      xor_r     <= xor_nxt;
      length_r  <= length_nxt;
      count_r   <= count_nxt;
    end
  end

  assign len_new       = {length_r[15:8], rx_byte};
  assign count_inc     = count_r + CW'(1);
  assign count_ext     = 16'(count_r);
  assign count_inc_ext = 16'(count_inc);

  always_comb begin
    phase_nxt   = phase_r;
    exp_seq_nxt = exp_seq_r;
    xor_nxt     = xor_r;
    length_nxt  = length_r;
    count_nxt   = count_r;

    res.kind          = stk_pkg::K_HUNT;
    res.data_byte     = rx_byte;
    res.payload_index = 9'd0;
    res.frame_length  = 10'd0;
    res.sequence_res  = 8'd0;

    unique case (phase_r)
      stk_pkg::PH_SEQ: begin
        if (rx_byte == 8'h01 || rx_byte == exp_seq_r) begin
          exp_seq_nxt      = rx_byte;
          xor_nxt          = xor_r ^ rx_byte;
          phase_nxt        = stk_pkg::PH_LEN_HI;
          res.kind         = stk_pkg::K_HEADER;
          res.sequence_res = rx_byte;
        end else begin
          phase_nxt = stk_pkg::PH_HUNT;
          res.kind  = stk_pkg::K_SEQREJ;
        end
      end
      stk_pkg::PH_LEN_HI: begin
        length_nxt       = {rx_byte, 8'h00};
        xor_nxt          = xor_r ^ rx_byte;
        phase_nxt        = stk_pkg::PH_LEN_LO;
        res.kind         = stk_pkg::K_HEADER;
        res.sequence_res = exp_seq_r;
      end
      stk_pkg::PH_LEN_LO: begin
        length_nxt       = len_new;
        res.sequence_res = exp_seq_r;
        if (len_new == 16'h0000 || len_new > MAX_LEN) begin
          phase_nxt = stk_pkg::PH_HUNT;
          res.kind  = stk_pkg::K_LENREJ;
        end else begin
          xor_nxt          = xor_r ^ rx_byte;
          phase_nxt        = stk_pkg::PH_TOKEN;
          res.kind         = stk_pkg::K_HEADER;
          res.frame_length = len_new[9:0];
        end
      end
      stk_pkg::PH_TOKEN: begin
        res.sequence_res = exp_seq_r;
        res.frame_length = length_r[9:0];
        if (rx_byte == cfg.token_byte) begin
          xor_nxt   = xor_r ^ rx_byte;
          count_nxt = '0;
          phase_nxt = stk_pkg::PH_DATA;
          res.kind  = stk_pkg::K_HEADER;
        end else begin
          phase_nxt = stk_pkg::PH_HUNT;
          res.kind  = stk_pkg::K_TOKREJ;
        end
      end
      stk_pkg::PH_DATA: begin
        res.sequence_res  = exp_seq_r;
        res.frame_length  = length_r[9:0];
        res.kind          = stk_pkg::K_PAYLOAD;
        res.payload_index = count_ext[8:0];
        xor_nxt           = xor_r ^ rx_byte;
        count_nxt         = count_inc;
        if (count_inc_ext >= length_r) begin
          phase_nxt = stk_pkg::PH_CHECK;
        end
      end
      stk_pkg::PH_CHECK: begin
        res.sequence_res = exp_seq_r;
        res.frame_length = length_r[9:0];
        if (rx_byte == xor_r) begin
          res.kind    = stk_pkg::K_GOOD;
          exp_seq_nxt = exp_seq_r + 8'd1;
        end else begin
          res.kind = stk_pkg::K_BADSUM;
        end
        phase_nxt = stk_pkg::PH_HUNT;
      end
      default: begin
        if (rx_byte == cfg.start_marker) begin
          xor_nxt   = cfg.start_marker;
          phase_nxt = stk_pkg::PH_SEQ;
          res.kind  = stk_pkg::K_HEADER;
        end else begin
          phase_nxt = stk_pkg::PH_HUNT;
          res.kind  = stk_pkg::K_HUNT;
        end
      end
    endcase
  end

`include "stk500v2_frame_receiver_assert.svh"

  `STK_ASSERT_NEXT(a_check_ends_frame, acc && phase_r == stk_pkg::PH_CHECK, phase_r == stk_pkg::PH_HUNT, "checksum word did not end the frame")
  `STK_ASSERT_NOW(a_payload_in_range, acc && phase_r == stk_pkg::PH_DATA, count_ext < length_r, "payload index past frame length")
  `STK_ASSERT_NEXT(a_seq_holds_idle, !acc, $stable(exp_seq_r), "expected sequence moved without a word")

endmodule

### hdl/stk_fifo.sv
// Back part: short result queue that decouples the parser from the consumer.
module stk_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  stk_pkg::result_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             empty,
  output stk_pkg::result_t rd_data
);

  stk_pkg::result_t                mem [stk_pkg::FIFO_DEPTH];
  logic [stk_pkg::FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [stk_pkg::FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [stk_pkg::FIFO_CW-1:0]     cnt_r, cnt_nxt;
  logic                            do_wr, do_rd;

  assign full    = (cnt_r == stk_pkg::FIFO_CW'(stk_pkg::FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + stk_pkg::FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + stk_pkg::FIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + stk_pkg::FIFO_CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - stk_pkg::FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

`include "stk500v2_frame_receiver_assert.svh"

  `STK_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= stk_pkg::FIFO_CW'(stk_pkg::FIFO_DEPTH), "queue count past depth")
  `STK_ASSERT_NEXT(a_cnt_up, do_wr && !do_rd, cnt_r == $past(cnt_r) + stk_pkg::FIFO_CW'(1), "queue count missed a write")
  `STK_ASSERT_NEXT(a_cnt_down, do_rd && !do_wr, cnt_r == $past(cnt_r) - stk_pkg::FIFO_CW'(1), "queue count missed a read")

endmodule
